// File: rtl/hap_pkg.sv
// hap_pkg: shared types and constants for the hysteresis actuator policy block.
// Holds the input/result transfer structs, the configuration struct and register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hap_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TEMP_W = 12;
    localparam int unsigned LUX_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CNT_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FAN_ON    = 3'd0;
    localparam logic [2:0] REG_FAN_OFF   = 3'd1;
    localparam logic [2:0] REG_LIGHT_ON  = 3'd2;
    localparam logic [2:0] REG_LIGHT_OFF = 3'd3;
    localparam logic [2:0] REG_MIN_HOLD  = 3'd4;

    // operations
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // health codes
    localparam logic [1:0] HEALTH_OK       = 2'd0;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
    localparam logic [1:0] HEALTH_FAULT    = 2'd2;

    // register reset values
    localparam logic signed [TEMP_W-1:0] FAN_ON_RST    = 12'sd300;
    localparam logic signed [TEMP_W-1:0] FAN_OFF_RST   = 12'sd270;
    localparam logic [LUX_W-1:0]         LIGHT_ON_RST  = 16'd100;
    localparam logic [LUX_W-1:0]         LIGHT_OFF_RST = 16'd200;
    localparam logic [TIME_W-1:0]        MIN_HOLD_RST  = 32'd5000;

    typedef struct packed {
        logic                     op;
        logic [TIME_W-1:0]        time_now;
        logic [1:0]               health_code;
        logic signed [TEMP_W-1:0] temperature;
        logic [LUX_W-1:0]         light_level;
    } t_in;

    typedef struct packed {
        logic              fan_drive;
        logic              light_drive;
        logic              alarm_drive;
        logic [CNT_W-1:0]  fan_switches;
        logic [CNT_W-1:0]  light_switches;
        logic [CNT_W-1:0]  blocked_switches;
    } t_out;

    typedef struct packed {
        logic signed [TEMP_W-1:0] fan_on_temp;
        logic signed [TEMP_W-1:0] fan_off_temp;
        logic [LUX_W-1:0]         light_on_level;
        logic [LUX_W-1:0]         light_off_level;
        logic [TIME_W-1:0]        min_hold_time;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/hysteresis_actuator_policy_core.sv
// hysteresis_actuator_policy_core: top level of the fan/light/alarm policy block.
// Holds the input and result registers and the transfer control.
// Depends on hap_pkg, hap_cfg and hap_policy.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one sensor sample or a
//   restart per transfer. Result channel (o_out_valid / i_out_stall / o_out) returns
//   exactly one result per input, in order.
//   Path: an item passes the input register, then the result register; the
//   policy update sits between them.
//   Throughput: one item per cycle when not stalled; an item's state update
//   completes with the result register load, so the next item follows directly.
//   Receiver stall: the result register holds; the input register keeps one more
//   item, after which o_in_stall rises until the result is taken.
//   Reset (i_rst_n low, synchronous): both stages empty, actuator flags, change
//   times and counters zero, thresholds and hold time back to their defaults.
//   Configuration: APB-style writes at byte address 4*index; pready is tied high.
//   Write registers only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_actuator_policy_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire hap_pkg::t_in               i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output hap_pkg::t_out                   o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hap_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hap_pkg::DATA_W-1:0] pwdata,
    output logic      [hap_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    hap_pkg::t_cfg cfg;
    hap_pkg::t_in  r_in;
    hap_pkg::t_out r_out;
    hap_pkg::t_out result;
    logic          r_in_valid, r_out_valid;
    logic          out_free, fire, in_xfer;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    hap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hap_policy u_policy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/hap_cfg.sv
// hap_cfg: APB-style configuration register file for the actuator policy.
// Depends on hap_pkg for the register map, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module hap_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hap_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hap_pkg::DATA_W-1:0] pwdata,
    output logic      [hap_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output hap_pkg::t_cfg                   o_cfg
);

    hap_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fan_on_temp     <= hap_pkg::FAN_ON_RST;
            r_cfg.fan_off_temp    <= hap_pkg::FAN_OFF_RST;
            r_cfg.light_on_level  <= hap_pkg::LIGHT_ON_RST;
            r_cfg.light_off_level <= hap_pkg::LIGHT_OFF_RST;
            r_cfg.min_hold_time   <= hap_pkg::MIN_HOLD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                hap_pkg::REG_FAN_ON: begin
                    r_cfg.fan_on_temp <= pwdata[hap_pkg::TEMP_W-1:0];
                end
                hap_pkg::REG_FAN_OFF: begin
                    r_cfg.fan_off_temp <= pwdata[hap_pkg::TEMP_W-1:0];
                end
                hap_pkg::REG_LIGHT_ON: begin
                    r_cfg.light_on_level <= pwdata[hap_pkg::LUX_W-1:0];
                end
                hap_pkg::REG_LIGHT_OFF: begin
                    r_cfg.light_off_level <= pwdata[hap_pkg::LUX_W-1:0];
                end
                hap_pkg::REG_MIN_HOLD: begin
                    r_cfg.min_hold_time <= pwdata[hap_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hap_pkg::REG_FAN_ON: begin
                prdata = {{(hap_pkg::DATA_W-hap_pkg::TEMP_W){r_cfg.fan_on_temp[hap_pkg::TEMP_W-1]}},
                          r_cfg.fan_on_temp};
            end
            hap_pkg::REG_FAN_OFF: begin
                prdata = {{(hap_pkg::DATA_W-hap_pkg::TEMP_W){r_cfg.fan_off_temp[hap_pkg::TEMP_W-1]}},
                          r_cfg.fan_off_temp};
            end
            hap_pkg::REG_LIGHT_ON: begin
                prdata = {{(hap_pkg::DATA_W-hap_pkg::LUX_W){1'b0}}, r_cfg.light_on_level};
            end
            hap_pkg::REG_LIGHT_OFF: begin
                prdata = {{(hap_pkg::DATA_W-hap_pkg::LUX_W){1'b0}}, r_cfg.light_off_level};
            end
            hap_pkg::REG_MIN_HOLD: begin
                prdata = r_cfg.min_hold_time;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/hap_policy.sv
// hap_policy: actuator state, change times and counters, with the per-item update logic.
// Produces the result of the item presented on i_item; state advances on i_fire.
// Depends on hap_pkg for t_in, t_out, t_cfg and the op/health codes.
`timescale 1ns / 1ps
`default_nettype none

module hap_policy (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire hap_pkg::t_in  i_item,
    input  wire hap_pkg::t_cfg i_cfg,
    output hap_pkg::t_out      o_result
);

    logic                       r_fan, r_light, r_alarm;
    logic [hap_pkg::TIME_W-1:0] r_fan_time, r_light_time;
    logic [hap_pkg::CNT_W-1:0]  r_fan_cnt, r_light_cnt, r_blk_cnt;

    logic                       n_fan, n_light, n_alarm;
    logic [hap_pkg::TIME_W-1:0] n_fan_time, n_light_time;
    logic [hap_pkg::CNT_W-1:0]  n_fan_cnt, n_light_cnt, n_blk_cnt;

    logic [hap_pkg::TIME_W-1:0] fan_age, light_age;
    logic                       fan_hold_ok, light_hold_ok;
    logic                       fan_want, light_want;
    logic                       fan_blk, light_blk;

    assign fan_age       = i_item.time_now - r_fan_time;
    assign light_age     = i_item.time_now - r_light_time;
    assign fan_hold_ok   = fan_age >= i_cfg.min_hold_time;
    assign light_hold_ok = light_age >= i_cfg.min_hold_time;

    assign fan_want   = r_fan ? !(i_item.temperature <= i_cfg.fan_off_temp)
                              : (i_item.temperature >= i_cfg.fan_on_temp);
    assign light_want = r_light ? !(i_item.light_level >= i_cfg.light_off_level)
                                : (i_item.light_level <= i_cfg.light_on_level);

    assign fan_blk   = (fan_want != r_fan) && !fan_hold_ok;
    assign light_blk = (light_want != r_light) && !light_hold_ok;

    always_comb begin
        n_fan        = r_fan;
        n_light      = r_light;
        n_alarm      = r_alarm;
        n_fan_time   = r_fan_time;
        n_light_time = r_light_time;
        n_fan_cnt    = r_fan_cnt;
        n_light_cnt  = r_light_cnt;
        n_blk_cnt    = r_blk_cnt;
        priority if (i_item.op == hap_pkg::OP_RESTART) begin
            n_fan        = 1'b0;
            n_light      = 1'b0;
            n_alarm      = 1'b0;
            n_fan_time   = i_item.time_now;
            n_light_time = i_item.time_now;
            n_fan_cnt    = '0;
            n_light_cnt  = '0;
            n_blk_cnt    = '0;
        end else if (i_item.health_code == hap_pkg::HEALTH_FAULT) begin
            n_alarm = 1'b1;
            if (r_fan) begin
                n_fan      = 1'b0;
                n_fan_time = i_item.time_now;
                n_fan_cnt  = r_fan_cnt + 1'b1;
            end
            if (r_light) begin
                n_light      = 1'b0;
                n_light_time = i_item.time_now;
                n_light_cnt  = r_light_cnt + 1'b1;
            end
        end else begin
            n_alarm = (i_item.health_code == hap_pkg::HEALTH_DEGRADED);
            if ((fan_want != r_fan) && fan_hold_ok) begin
                n_fan      = fan_want;
                n_fan_time = i_item.time_now;
                n_fan_cnt  = r_fan_cnt + 1'b1;
            end
            if ((light_want != r_light) && light_hold_ok) begin
                n_light      = light_want;
                n_light_time = i_item.time_now;
                n_light_cnt  = r_light_cnt + 1'b1;
            end
            n_blk_cnt = r_blk_cnt + {{(hap_pkg::CNT_W-2){1'b0}},
                                     {1'b0, fan_blk} + {1'b0, light_blk}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan        <= 1'b0;
            r_light      <= 1'b0;
            r_alarm      <= 1'b0;
            r_fan_time   <= '0;
            r_light_time <= '0;
            r_fan_cnt    <= '0;
            r_light_cnt  <= '0;
            r_blk_cnt    <= '0;
        end else if (i_fire) begin
            r_fan        <= n_fan;
            r_light      <= n_light;
            r_alarm      <= n_alarm;
            r_fan_time   <= n_fan_time;
            r_light_time <= n_light_time;
            r_fan_cnt    <= n_fan_cnt;
            r_light_cnt  <= n_light_cnt;
            r_blk_cnt    <= n_blk_cnt;
        end
    end

    assign o_result.fan_drive        = n_fan;
    assign o_result.light_drive      = n_light;
    assign o_result.alarm_drive      = n_alarm;
    assign o_result.fan_switches     = n_fan_cnt;
    assign o_result.light_switches   = n_light_cnt;
    assign o_result.blocked_switches = n_blk_cnt;

endmodule

`default_nettype wire
